### sv/assert_macros.svh
// Assertion macros shared by the clock calendar RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);

`endif

### sv/tsrtc_pkg.sv
// Types, constants and calendar functions for the clock calendar with alarm.
// Depends on nothing; used by every module of the block.
`default_nettype none

package tsrtc_pkg;

   // Timebase.
   localparam int TPS = 10;

   // Field widths.
   localparam int CMD_W   = 3;
   localparam int HOUR_W  = 5;
   localparam int MIN_W   = 6;
   localparam int SEC_W   = 6;
   localparam int TENTH_W = 4;
   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int ALARM_W = 21;

   // Calendar limits.
   localparam int LAST_YEAR = 9999;
   localparam int ALARM_MAX = 2 ** ALARM_W - 1;

   // Tick weights of the alarm duration fields.
   localparam int SEC_TICKS  = TPS;
   localparam int MIN_TICKS  = 60 * TPS;
   localparam int HOUR_TICKS = 3600 * TPS;

   // Divisibility by 25 through the modular inverse of 25 on the year width.
   localparam logic [YEAR_W-1:0] INV25     = 14'd7209;
   localparam logic [YEAR_W-1:0] DIV25_MAX = 14'd655;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_TICK        = 3'd0;
   localparam logic [CMD_W-1:0] CMD_SET_TIME    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_SET_DATE    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SET_ALARM   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CLEAR_ALARM = 3'd4;

   // Decoded operation strobes, at most one set, only for an item in flight.
   typedef struct packed {
      logic tick;
      logic set_time;
      logic set_date;
      logic set_alarm;
      logic clear_alarm;
   } op_type;

   // Gregorian leap year: divisible by 4 and not by 100, or divisible by 400.
   // Divisible by 100 is divisible by 4 and by 25; by 400 is by 16 and by 25.
   function automatic logic leap_year(input logic [YEAR_W-1:0] year);
      logic [YEAR_W-1:0] prod;
      logic div25;
      prod  = year * INV25;
      div25 = (prod <= DIV25_MAX);
      return ((year[1:0] == 2'd0) && !div25) || ((year[3:0] == 4'd0) && div25);
   endfunction

   // Length of a month; codes outside 1 to 12 give 31.
   function automatic logic [DAY_W-1:0] days_of_month(input logic [MONTH_W-1:0] month,
                                                      input logic leap);
      logic [DAY_W-1:0] len;
      unique case (month)
         4'd2:                      len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
         default:                   len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

### sv/tsrtc_time.sv
// Time-of-day counter: tenth, second, minute and hour with carry chain.
// Depends on tsrtc_pkg.
`default_nettype none

module tsrtc_time (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire tsrtc_pkg::op_type             op,
   input  wire logic [tsrtc_pkg::HOUR_W-1:0]  in_hour,
   input  wire logic [tsrtc_pkg::MIN_W-1:0]   in_minute,
   input  wire logic [tsrtc_pkg::SEC_W-1:0]   in_second,
   input  wire logic [tsrtc_pkg::TENTH_W-1:0] in_tenth,
   output logic      [tsrtc_pkg::HOUR_W-1:0]  hour_in,
   output logic      [tsrtc_pkg::MIN_W-1:0]   minute_in,
   output logic      [tsrtc_pkg::SEC_W-1:0]   second_in,
   output logic      [tsrtc_pkg::TENTH_W-1:0] tenth_in,
   output logic                               day_wrap,
   output logic                               time_ok
);

   logic [tsrtc_pkg::HOUR_W-1:0]  hour_ff;
   logic [tsrtc_pkg::MIN_W-1:0]   minute_ff;
   logic [tsrtc_pkg::SEC_W-1:0]   second_ff;
   logic [tsrtc_pkg::TENTH_W-1:0] tenth_ff;
   logic tenth_last, second_last, minute_last, hour_last, set_valid;

   // Last value of each digit before it carries.
   assign tenth_last  = (tenth_ff  == tsrtc_pkg::TENTH_W'(tsrtc_pkg::TPS - 1));
   assign second_last = (second_ff == tsrtc_pkg::SEC_W'(59));
   assign minute_last = (minute_ff == tsrtc_pkg::MIN_W'(59));
   assign hour_last   = (hour_ff   == tsrtc_pkg::HOUR_W'(23));

   // A set-time beat is taken only when every field is in range.
   assign set_valid = (in_tenth  < tsrtc_pkg::TENTH_W'(tsrtc_pkg::TPS)) &&
                      (in_second < tsrtc_pkg::SEC_W'(60)) &&
                      (in_minute < tsrtc_pkg::MIN_W'(60)) &&
                      (in_hour   < tsrtc_pkg::HOUR_W'(24));

   // Next time of day.
   always_comb begin
      hour_in   = hour_ff;
      minute_in = minute_ff;
      second_in = second_ff;
      tenth_in  = tenth_ff;
      day_wrap  = 1'b0;
      time_ok   = 1'b0;
      if (op.tick) begin
         tenth_in = tenth_ff + 1'b1;
         if (tenth_last) begin
            tenth_in  = '0;
            second_in = second_ff + 1'b1;
            if (second_last) begin
               second_in = '0;
               minute_in = minute_ff + 1'b1;
               if (minute_last) begin
                  minute_in = '0;
                  hour_in   = hour_ff + 1'b1;
                  if (hour_last) begin
                     hour_in  = '0;
                     day_wrap = 1'b1;
                  end
               end
            end
         end
      end else if (op.set_time) begin
         time_ok = set_valid;
         if (set_valid) begin
            hour_in   = in_hour;
            minute_in = in_minute;
            second_in = in_second;
            tenth_in  = in_tenth;
         end
      end
   end

   // Time-of-day registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         hour_ff   <= '0;
         minute_ff <= '0;
         second_ff <= '0;
         tenth_ff  <= '0;
      end else begin
         hour_ff   <= hour_in;
         minute_ff <= minute_in;
         second_ff <= second_in;
         tenth_ff  <= tenth_in;
      end
   end

endmodule

`default_nettype wire

### sv/tsrtc_date.sv
// Date counter with Gregorian leap years and set-date validation.
// Depends on tsrtc_pkg.
`default_nettype none

module tsrtc_date (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire tsrtc_pkg::op_type             op,
   input  wire logic                          day_wrap,
   input  wire logic [tsrtc_pkg::YEAR_W-1:0]  in_year,
   input  wire logic [tsrtc_pkg::MONTH_W-1:0] in_month,
   input  wire logic [tsrtc_pkg::DAY_W-1:0]   in_day,
   output logic      [tsrtc_pkg::YEAR_W-1:0]  year_in,
   output logic      [tsrtc_pkg::MONTH_W-1:0] month_in,
   output logic      [tsrtc_pkg::DAY_W-1:0]   day_in,
   output logic                               date_ok
);

   logic [tsrtc_pkg::YEAR_W-1:0]  year_ff;
   logic [tsrtc_pkg::MONTH_W-1:0] month_ff;
   logic [tsrtc_pkg::DAY_W-1:0]   day_ff;
   logic [tsrtc_pkg::DAY_W-1:0]   cur_len, set_len;
   logic set_valid;

   // Month lengths for the current date and for the requested date.
   assign cur_len = tsrtc_pkg::days_of_month(month_ff, tsrtc_pkg::leap_year(year_ff));
   assign set_len = tsrtc_pkg::days_of_month(in_month, tsrtc_pkg::leap_year(in_year));

   assign set_valid = (in_year < tsrtc_pkg::YEAR_W'(tsrtc_pkg::LAST_YEAR)) &&
                      (in_month >= 4'd1) && (in_month <= 4'd12) &&
                      (in_day >= 5'd1) && (in_day <= set_len);

   // Next date: roll day, month and year at midnight, or load a valid date.
   always_comb begin
      year_in  = year_ff;
      month_in = month_ff;
      day_in   = day_ff;
      date_ok  = 1'b0;
      if (op.tick) begin
         if (day_wrap) begin
            day_in = day_ff + 1'b1;
            if (day_ff >= cur_len) begin
               day_in   = 5'd1;
               month_in = month_ff + 1'b1;
               if (month_ff >= 4'd12) begin
                  month_in = 4'd1;
                  if (year_ff >= tsrtc_pkg::YEAR_W'(tsrtc_pkg::LAST_YEAR)) begin
                     year_in = '0;
                  end else begin
                     year_in = year_ff + 1'b1;
                  end
               end
            end
         end
      end else if (op.set_date) begin
         date_ok = set_valid;
         if (set_valid) begin
            year_in  = in_year;
            month_in = in_month;
            day_in   = in_day;
         end
      end
   end

   // Date registers; reset gives day 1 of month 1 of year 0.
   always_ff @(posedge clock) begin
      if (reset) begin
         year_ff  <= '0;
         month_ff <= 4'd1;
         day_ff   <= 5'd1;
      end else begin
         year_ff  <= year_in;
         month_ff <= month_in;
         day_ff   <= day_in;
      end
   end

endmodule

`default_nettype wire

### sv/tsrtc_alarm.sv
// One-shot relative alarm: saturating load and countdown on ticks.
// Depends on tsrtc_pkg.
`default_nettype none

module tsrtc_alarm (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire tsrtc_pkg::op_type             op,
   input  wire logic [tsrtc_pkg::HOUR_W-1:0]  in_hour,
   input  wire logic [tsrtc_pkg::MIN_W-1:0]   in_minute,
   input  wire logic [tsrtc_pkg::SEC_W-1:0]   in_second,
   input  wire logic [tsrtc_pkg::TENTH_W-1:0] in_tenth,
   output logic                               fired
);

   logic [tsrtc_pkg::ALARM_W-1:0] count_ff, count_in, count_dec, load_val;
   logic                          on_ff, on_in;
   logic [31:0]                   load_sum;

   // Duration in ticks, by constant weights, saturated to the counter width.
   assign load_sum = 32'(in_tenth) +
                     32'(in_second) * 32'(tsrtc_pkg::SEC_TICKS) +
                     32'(in_minute) * 32'(tsrtc_pkg::MIN_TICKS) +
                     32'(in_hour)   * 32'(tsrtc_pkg::HOUR_TICKS);
   assign load_val = (load_sum > 32'(tsrtc_pkg::ALARM_MAX)) ?
                     tsrtc_pkg::ALARM_W'(tsrtc_pkg::ALARM_MAX) :
                     load_sum[tsrtc_pkg::ALARM_W-1:0];

   // The count stops at zero.
   assign count_dec = (count_ff != '0) ? count_ff - 1'b1 : count_ff;

   // Countdown and enable; firing disarms the alarm.
   always_comb begin
      count_in = count_ff;
      on_in    = on_ff;
      fired    = 1'b0;
      if (op.tick) begin
         if (on_ff) begin
            count_in = count_dec;
            if (count_dec == '0) begin
               fired = 1'b1;
               on_in = 1'b0;
            end
         end
      end else if (op.set_alarm) begin
         count_in = load_val;
         on_in    = 1'b1;
      end else if (op.clear_alarm) begin
         on_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         on_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         on_ff    <= on_in;
      end
   end

endmodule

`default_nettype wire

### sv/tenth_second_clock_calendar_alarm_unit.sv
// Clock calendar with one-shot alarm: top level.
// A request beat is held in the request register, passes the single update and is then
// presented from the result register. Throughput: one beat per cycle while rsp_stall does
// not hold a waiting result, set by the single update pass between the two registers.
// Reset (synchronous): time 00:00:00.0, date day 1 month 1 year 0, alarm off.
// Depends on tsrtc_pkg, tsrtc_time, tsrtc_date, tsrtc_alarm, assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module tenth_second_clock_calendar_alarm_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [tsrtc_pkg::CMD_W-1:0]   req_cmd,
   input  wire logic [tsrtc_pkg::HOUR_W-1:0]  req_in_hour,
   input  wire logic [tsrtc_pkg::MIN_W-1:0]   req_in_minute,
   input  wire logic [tsrtc_pkg::SEC_W-1:0]   req_in_second,
   input  wire logic [tsrtc_pkg::TENTH_W-1:0] req_in_tenth,
   input  wire logic [tsrtc_pkg::YEAR_W-1:0]  req_in_year,
   input  wire logic [tsrtc_pkg::MONTH_W-1:0] req_in_month,
   input  wire logic [tsrtc_pkg::DAY_W-1:0]   req_in_day,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic      [tsrtc_pkg::HOUR_W-1:0]  rsp_out_hour,
   output logic      [tsrtc_pkg::MIN_W-1:0]   rsp_out_minute,
   output logic      [tsrtc_pkg::SEC_W-1:0]   rsp_out_second,
   output logic      [tsrtc_pkg::TENTH_W-1:0] rsp_out_tenth,
   output logic      [tsrtc_pkg::YEAR_W-1:0]  rsp_out_year,
   output logic      [tsrtc_pkg::MONTH_W-1:0] rsp_out_month,
   output logic      [tsrtc_pkg::DAY_W-1:0]   rsp_out_day,
   output logic                               rsp_alarm_fired,
   output logic                               rsp_ok
);

   // Request register.
   logic                          in_valid_ff, in_valid_in;
   logic [tsrtc_pkg::CMD_W-1:0]   cmd_ff;
   logic [tsrtc_pkg::HOUR_W-1:0]  hour_ff;
   logic [tsrtc_pkg::MIN_W-1:0]   minute_ff;
   logic [tsrtc_pkg::SEC_W-1:0]   second_ff;
   logic [tsrtc_pkg::TENTH_W-1:0] tenth_ff;
   logic [tsrtc_pkg::YEAR_W-1:0]  year_ff;
   logic [tsrtc_pkg::MONTH_W-1:0] month_ff;
   logic [tsrtc_pkg::DAY_W-1:0]   day_ff;

   // Result register.
   logic                          out_valid_ff, out_valid_in;
   logic [tsrtc_pkg::HOUR_W-1:0]  out_hour_ff;
   logic [tsrtc_pkg::MIN_W-1:0]   out_minute_ff;
   logic [tsrtc_pkg::SEC_W-1:0]   out_second_ff;
   logic [tsrtc_pkg::TENTH_W-1:0] out_tenth_ff;
   logic [tsrtc_pkg::YEAR_W-1:0]  out_year_ff;
   logic [tsrtc_pkg::MONTH_W-1:0] out_month_ff;
   logic [tsrtc_pkg::DAY_W-1:0]   out_day_ff;
   logic                          out_fired_ff, out_ok_ff;

   // Values after the item in flight.
   logic [tsrtc_pkg::HOUR_W-1:0]  hour_in;
   logic [tsrtc_pkg::MIN_W-1:0]   minute_in;
   logic [tsrtc_pkg::SEC_W-1:0]   second_in;
   logic [tsrtc_pkg::TENTH_W-1:0] tenth_in;
   logic [tsrtc_pkg::YEAR_W-1:0]  year_in;
   logic [tsrtc_pkg::MONTH_W-1:0] month_in;
   logic [tsrtc_pkg::DAY_W-1:0]   day_in;
   logic                          day_wrap, time_ok, date_ok, fired, ok;

   logic              advance, accept, out_blocked;
   logic              time_in_range, date_in_range;
   tsrtc_pkg::op_type op;

   // The held beat moves on unless a finished result is still waiting.
   assign out_blocked = out_valid_ff && rsp_stall;
   assign advance     = in_valid_ff && !out_blocked;
   assign req_stall   = in_valid_ff && !advance;
   assign accept      = req_valid && !req_stall;

   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign out_valid_in = advance || out_blocked;

   // Command decode; strobes fire only for the beat that moves this cycle.
   always_comb begin
      op = '0;
      if (advance) begin
         op.tick        = (cmd_ff == tsrtc_pkg::CMD_TICK);
         op.set_time    = (cmd_ff == tsrtc_pkg::CMD_SET_TIME);
         op.set_date    = (cmd_ff == tsrtc_pkg::CMD_SET_DATE);
         op.set_alarm   = (cmd_ff == tsrtc_pkg::CMD_SET_ALARM);
         op.clear_alarm = (cmd_ff == tsrtc_pkg::CMD_CLEAR_ALARM);
      end
   end

   // Unknown commands are rejected.
   assign ok = op.tick || op.set_alarm || op.clear_alarm ||
               (op.set_time && time_ok) || (op.set_date && date_ok);

   tsrtc_time u_time (
      .clock     (clock),
      .reset     (reset),
      .op        (op),
      .in_hour   (hour_ff),
      .in_minute (minute_ff),
      .in_second (second_ff),
      .in_tenth  (tenth_ff),
      .hour_in   (hour_in),
      .minute_in (minute_in),
      .second_in (second_in),
      .tenth_in  (tenth_in),
      .day_wrap  (day_wrap),
      .time_ok   (time_ok)
   );

   tsrtc_date u_date (
      .clock    (clock),
      .reset    (reset),
      .op       (op),
      .day_wrap (day_wrap),
      .in_year  (year_ff),
      .in_month (month_ff),
      .in_day   (day_ff),
      .year_in  (year_in),
      .month_in (month_in),
      .day_in   (day_in),
      .date_ok  (date_ok)
   );

   tsrtc_alarm u_alarm (
      .clock     (clock),
      .reset     (reset),
      .op        (op),
      .in_hour   (hour_ff),
      .in_minute (minute_ff),
      .in_second (second_ff),
      .in_tenth  (tenth_ff),
      .fired     (fired)
   );

   // Valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Request payload is captured on an accepted beat.
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff    <= req_cmd;
         hour_ff   <= req_in_hour;
         minute_ff <= req_in_minute;
         second_ff <= req_in_second;
         tenth_ff  <= req_in_tenth;
         year_ff   <= req_in_year;
         month_ff  <= req_in_month;
         day_ff    <= req_in_day;
      end
   end

   // Result payload is captured when the held beat is processed.
   always_ff @(posedge clock) begin
      if (advance) begin
         out_hour_ff   <= hour_in;
         out_minute_ff <= minute_in;
         out_second_ff <= second_in;
         out_tenth_ff  <= tenth_in;
         out_year_ff   <= year_in;
         out_month_ff  <= month_in;
         out_day_ff    <= day_in;
         out_fired_ff  <= fired;
         out_ok_ff     <= ok;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_out_hour    = out_hour_ff;
   assign rsp_out_minute  = out_minute_ff;
   assign rsp_out_second  = out_second_ff;
   assign rsp_out_tenth   = out_tenth_ff;
   assign rsp_out_year    = out_year_ff;
   assign rsp_out_month   = out_month_ff;
   assign rsp_out_day     = out_day_ff;
   assign rsp_alarm_fired = out_fired_ff;
   assign rsp_ok          = out_ok_ff;

   // Range checks on the reported time and date.
   assign time_in_range = (rsp_out_hour < 5'd24) && (rsp_out_minute < 6'd60) &&
                          (rsp_out_second < 6'd60);
   assign date_in_range = (rsp_out_month >= 4'd1) && (rsp_out_month <= 4'd12) &&
                          (rsp_out_day >= 5'd1);

   // The request side stalls only behind a blocked result.
   `ASSERT_IMPL(a_stall_cause, clock, reset, req_stall, out_blocked, "stall, no blocked beat")
   // Only an accepted tick can fire the alarm.
   `ASSERT_IMPL(a_fire_ok, clock, reset, rsp_valid && rsp_alarm_fired, rsp_ok, "fire without ok")
   // The reported hour, minute and second stay in range.
   `ASSERT_IMPL(a_time_range, clock, reset, rsp_valid, time_in_range, "time out of range")
   // The reported month stays in range and the reported day is at least 1.
   `ASSERT_IMPL(a_date_range, clock, reset, rsp_valid, date_in_range, "date out of range")

endmodule

`default_nettype wire
